FILE: rtl/stratified_timed_event_queue_defines.svh
// Assertion macros used by the stratified timed event queue top level.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef STRATIFIED_TIMED_EVENT_QUEUE_DEFINES_SVH
`define STRATIFIED_TIMED_EVENT_QUEUE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STEQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/steq_pkg.sv
`timescale 1ns / 1ps
// Shared codes, widths and types of the stratified timed event queue.
// No dependencies; the top level, front end and back end refer to it by scoped names.
package steq_pkg;

    localparam int CMD_W  = 2;
    localparam int CLS_W  = 3;
    localparam int STAT_W = 3;
    localparam int TIME_W = 63;
    localparam int TAG_W  = 32;
    localparam int NUM_CLASSES = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP    = 2'd2;

    localparam logic [CLS_W-1:0] CLS_ACTIVE = 3'd0;
    localparam logic [CLS_W-1:0] CLS_NBA    = 3'd1;
    localparam logic [CLS_W-1:0] CLS_RWSYNC = 3'd2;
    localparam logic [CLS_W-1:0] CLS_ROSYNC = 3'd3;
    localparam logic [CLS_W-1:0] CLS_DEL    = 3'd4;

    localparam logic [STAT_W-1:0] ST_ACC   = 3'd0;
    localparam logic [STAT_W-1:0] ST_RET   = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 3'd2;
    localparam logic [STAT_W-1:0] ST_REJ   = 3'd3;
    localparam logic [STAT_W-1:0] ST_VIOL  = 3'd4;

    // One decoded request as it leaves the front end.
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [TIME_W-1:0] delay;
        logic [CLS_W-1:0]  cls;
        logic [TAG_W-1:0]  tag;
        logic              bad;
        logic              dz;
    } req_t;

    // One result as the back end hands it over.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [TAG_W-1:0]  tag;
        logic [CLS_W-1:0]  cls;
        logic [TIME_W-1:0] etime;
    } rsp_t;

endpackage

FILE: rtl/stratified_timed_event_queue.sv
`timescale 1ns / 1ps
// Top level of the stratified timed event queue: front end, back end, result register.
// Depends on steq_pkg, steq_front, steq_back and the assertion macro header.
//
// Usage: requests arrive on the req channel (req_valid/req_ready) carrying cmd,
// delay, event_class and tag; every request beat yields exactly one result beat
// on the rsp channel (rsp_valid/rsp_ready) carrying status, out_tag, out_class
// and fire_time, in request order.
// A two entry request queue lets the front take beats while the back end works.
// Each insert, push or pop that decode does not turn away scans the slot time
// memory one slot per cycle. An insert or push that opens a new slot also passes
// through S_ALLOC, and an insert that joins a non-empty list through S_LINK; a
// pop scans again for each emptied slot it retires first. Rejected and dropped
// requests are answered from decode without a scan, but an insert or push whose
// time has no slot and finds no free one is rejected after the scan.
// The back end holds one request at a time and takes no new request until the
// result of the last one has been handed over.
// Reset empties every slot, list and the free pool at once; no clearing pass runs.
// A stalled receiver holds the result in the output register; the back end then
// waits and the request queue fills before req_ready falls.
`include "stratified_timed_event_queue_defines.svh"
module stratified_timed_event_queue #(
    parameter int MAX_SLOTS  = 64,
    parameter int MAX_EVENTS = 1024,
    parameter int TAG_BITS   = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  logic [steq_pkg::CMD_W-1:0]    cmd,
    input  logic [steq_pkg::TIME_W-1:0]   delay,
    input  logic [steq_pkg::CLS_W-1:0]    event_class,
    input  logic [steq_pkg::TAG_W-1:0]    tag,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [steq_pkg::STAT_W-1:0]   status,
    output logic [steq_pkg::TAG_W-1:0]    out_tag,
    output logic [steq_pkg::CLS_W-1:0]    out_class,
    output logic [steq_pkg::TIME_W-1:0]   fire_time
);

    logic           q_valid, q_ready;
    steq_pkg::req_t q_item;
    logic           back_vld, back_rdy;
    steq_pkg::rsp_t back_res;
    logic           rsp_valid_reg, rsp_valid_next;
    steq_pkg::rsp_t rsp_reg;
    logic           ret_beat, payload_zero;

    steq_front u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready),
        .cmd(cmd), .delay(delay), .event_class(event_class), .tag(tag),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item));

    steq_back #(
        .MAX_SLOTS(MAX_SLOTS), .MAX_EVENTS(MAX_EVENTS), .TAG_BITS(TAG_BITS)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .res_valid(back_vld), .res_ready(back_rdy), .res(back_res));

    assign back_rdy = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (back_vld && back_rdy)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_vld && back_rdy)
        begin
            rsp_reg <= back_res;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_reg.status;
    assign out_tag    = rsp_reg.tag;
    assign out_class  = rsp_reg.cls;
    assign fire_time  = rsp_reg.etime;

    assign ret_beat     = (status == steq_pkg::ST_RET);
    assign payload_zero = (out_tag == '0) && (out_class == '0) && (fire_time == '0);

    // Only a returned event carries payload fields.
    `STEQ_ASSERT_NOW(a_quiet_fields, rsp_valid && !ret_beat, payload_zero,
        "payload set on a non-event result")
    `STEQ_ASSERT_NOW(a_status_code, rsp_valid, status <= steq_pkg::ST_VIOL,
        "unknown status code")
    `STEQ_ASSERT_NEXT(a_result_lands, back_vld && back_rdy, rsp_valid,
        "result from back end not registered")

endmodule

FILE: rtl/steq_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module steq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/steq_front.sv
`timescale 1ns / 1ps
// Front end: takes request beats, classifies them and queues them for the back end.
// Depends on steq_pkg.
module steq_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  logic [steq_pkg::CMD_W-1:0]  cmd,
    input  logic [steq_pkg::TIME_W-1:0] delay,
    input  logic [steq_pkg::CLS_W-1:0]  event_class,
    input  logic [steq_pkg::TAG_W-1:0]  tag,
    output logic                        q_valid,
    input  logic                        q_ready,
    output steq_pkg::req_t              q_item
);

    steq_pkg::req_t ent_reg [2];
    logic           wptr_reg, wptr_next;
    logic           rptr_reg, rptr_next;
    logic [1:0]     cnt_reg, cnt_next;
    steq_pkg::req_t dec;
    logic           push, pop;

    always_comb
    begin
        dec.cmd   = cmd;
        dec.delay = delay;
        dec.cls   = event_class;
        dec.tag   = tag;
        dec.dz    = (delay == '0);
        // Unknown commands and out of range classes on an insert are answered without touching state.
        dec.bad   = (cmd != steq_pkg::CMD_INSERT && cmd != steq_pkg::CMD_PUSH &&
                     cmd != steq_pkg::CMD_POP) ||
                    (cmd == steq_pkg::CMD_INSERT && event_class > steq_pkg::CLS_DEL);
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_item    = ent_reg[rptr_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        wptr_next = push ? ~wptr_reg : wptr_reg;
        rptr_next = pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= dec;
        end
    end

endmodule

FILE: rtl/steq_back.sv
`timescale 1ns / 1ps
// Back end: slot scan, list and free pool sequencer over the event memories.
// Depends on steq_pkg and steq_ram.
module steq_back #(
    parameter int MAX_SLOTS  = 64,
    parameter int MAX_EVENTS = 1024,
    parameter int TAG_BITS   = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    output logic           q_ready,
    input  steq_pkg::req_t q_item,
    output logic           res_valid,
    input  logic           res_ready,
    output steq_pkg::rsp_t res
);

    localparam int SW  = $clog2(MAX_SLOTS);
    localparam int SCW = $clog2(MAX_SLOTS + 1);
    localparam int EW  = $clog2(MAX_EVENTS);
    localparam int LW  = $clog2(MAX_EVENTS + 1);
    localparam int SB  = (TAG_BITS < steq_pkg::TAG_W) ? TAG_BITS : steq_pkg::TAG_W;
    localparam int NC  = steq_pkg::NUM_CLASSES;
    localparam int TW  = steq_pkg::TIME_W;
    localparam logic [LW-1:0]  NULL_LINK = LW'(MAX_EVENTS);
    localparam logic [SCW-1:0] SCAN_END  = SCW'(MAX_SLOTS);

    typedef struct packed {
        logic [LW-1:0] head;
        logic [LW-1:0] tail;
    } ends_t;
    typedef ends_t [NC-1:0] row_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SCAN, S_ALLOC, S_LRD, S_LUPD, S_LINK,
        S_PRD, S_PCHK, S_PPOP, S_RES
    } state_t;

    state_t                    state_reg, state_next;
    steq_pkg::req_t            item_reg, item_next;
    steq_pkg::rsp_t            res_reg, res_next;
    logic [TW-1:0]             cur_reg, cur_next;
    logic                      ro_reg, ro_next;
    logic [MAX_SLOTS-1:0]      valid_reg, valid_next;
    logic [LW-1:0]             fresh_reg, fresh_next;
    logic [LW-1:0]             recyc_reg, recyc_next;
    logic [SCW-1:0]            scan_reg, scan_next;
    logic                      pend_reg, pend_next;
    logic [SW-1:0]             pidx_reg, pidx_next;
    logic                      found_reg, found_next;
    logic [SW-1:0]             fidx_reg, fidx_next;
    logic                      ffree_reg, ffree_next;
    logic [SW-1:0]             free_reg, free_next;
    logic [TW-1:0]             best_reg, best_next;
    logic [TW-1:0]             target_reg, target_next;
    logic [SW-1:0]             slot_reg, slot_next;
    row_t                      row_reg, row_next;
    logic [LW-1:0]             ent_reg, ent_next;
    logic [LW-1:0]             tail_reg, tail_next;
    logic [steq_pkg::CLS_W-1:0] pcls_reg, pcls_next;

    // Memory ports.
    logic              st_we;
    logic [SW-1:0]     st_waddr, st_raddr;
    logic [TW-1:0]     st_wdata, st_rdata;
    logic              ls_we;
    logic [SW-1:0]     ls_waddr, ls_raddr;
    row_t              ls_wdata, ls_rdata;
    logic              tg_we;
    logic [EW-1:0]     tg_waddr, tg_raddr;
    logic [SB+2:0]     tg_wdata, tg_rdata;
    logic              lk_we;
    logic [EW-1:0]     lk_waddr, lk_raddr;
    logic [LW-1:0]     lk_wdata, lk_rdata;

    steq_ram #(.WIDTH(TW), .DEPTH(MAX_SLOTS)) u_slot_time (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata));
    steq_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_SLOTS)) u_lists (
        .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(ls_wdata),
        .raddr(ls_raddr), .rdata(ls_rdata));
    steq_ram #(.WIDTH(SB + 3), .DEPTH(MAX_EVENTS)) u_tags (
        .clk(clk), .we(tg_we), .waddr(tg_waddr), .wdata(tg_wdata),
        .raddr(tg_raddr), .rdata(tg_rdata));
    steq_ram #(.WIDTH(LW), .DEPTH(MAX_EVENTS)) u_links (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(lk_raddr), .rdata(lk_rdata));

    logic [TW:0]   sum;
    logic          have_free;
    logic          pop_cmd;
    logic          use_r;
    logic [LW-1:0] e;
    logic [steq_pkg::CLS_W-1:0] c;
    row_t          r;
    row_t          empty_row;
    logic          scan_done;
    logic          cand;

    assign q_ready   = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RES);
    assign res       = res_reg;

    always_comb
    begin
        for (int k = 0; k < NC; k++)
        begin
            empty_row[k].head = NULL_LINK;
            empty_row[k].tail = NULL_LINK;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        res_next    = res_reg;
        cur_next    = cur_reg;
        ro_next     = ro_reg;
        valid_next  = valid_reg;
        fresh_next  = fresh_reg;
        recyc_next  = recyc_reg;
        scan_next   = scan_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        found_next  = found_reg;
        fidx_next   = fidx_reg;
        ffree_next  = ffree_reg;
        free_next   = free_reg;
        best_next   = best_reg;
        target_next = target_reg;
        slot_next   = slot_reg;
        row_next    = row_reg;
        ent_next    = ent_reg;
        tail_next   = tail_reg;
        pcls_next   = pcls_reg;

        st_we = 1'b0; st_waddr = slot_reg; st_wdata = target_reg; st_raddr = scan_reg[SW-1:0];
        ls_we = 1'b0; ls_waddr = slot_reg; ls_wdata = empty_row; ls_raddr = slot_reg;
        tg_we = 1'b0; tg_waddr = ent_reg[EW-1:0]; tg_wdata = '0; tg_raddr = ent_reg[EW-1:0];
        lk_we = 1'b0; lk_waddr = ent_reg[EW-1:0]; lk_wdata = NULL_LINK;
        lk_raddr = recyc_reg[EW-1:0];

        sum       = {1'b0, cur_reg} + {1'b0, item_reg.delay};
        have_free = (recyc_reg != NULL_LINK) || (fresh_reg != NULL_LINK);
        pop_cmd   = (item_reg.cmd == steq_pkg::CMD_POP);
        use_r     = (recyc_reg != NULL_LINK);
        e         = use_r ? recyc_reg : fresh_reg;
        c         = steq_pkg::CLS_ACTIVE;
        r         = ls_rdata;
        scan_done = (scan_reg == SCAN_END) && !pend_reg;
        cand      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    item_next  = q_item;
                    state_next = S_DEC;
                end
            end

            S_DEC:
            begin
                res_next   = '0;
                scan_next  = '0;
                pend_next  = 1'b0;
                found_next = 1'b0;
                ffree_next = 1'b0;
                state_next = S_RES;
                if (item_reg.bad)
                begin
                    res_next.status = steq_pkg::ST_REJ;
                end
                else if (item_reg.cmd == steq_pkg::CMD_INSERT)
                begin
                    if (ro_reg && item_reg.dz && item_reg.cls <= steq_pkg::CLS_RWSYNC)
                    begin
                        res_next.status = steq_pkg::ST_VIOL;
                    end
                    else if (sum[TW] || !have_free)
                    begin
                        res_next.status = steq_pkg::ST_REJ;
                    end
                    else
                    begin
                        target_next = sum[TW-1:0];
                        state_next  = S_SCAN;
                    end
                end
                else if (item_reg.cmd == steq_pkg::CMD_PUSH)
                begin
                    if (ro_reg)
                    begin
                        res_next.status = steq_pkg::ST_VIOL;
                    end
                    else if (!have_free)
                    begin
                        res_next.status = steq_pkg::ST_REJ;
                    end
                    else
                    begin
                        target_next = cur_reg;
                        state_next  = S_SCAN;
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // One slot address goes out per cycle; its time is compared in the next cycle.
                if (scan_reg != SCAN_END)
                begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                    pidx_next = scan_reg[SW-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (pop_cmd)
                    begin
                        cand = valid_reg[pidx_reg] && (!found_reg || st_rdata < best_reg);
                        if (cand)
                        begin
                            found_next = 1'b1;
                            best_next  = st_rdata;
                            fidx_next  = pidx_reg;
                        end
                    end
                    else
                    begin
                        if (valid_reg[pidx_reg] && st_rdata == target_reg)
                        begin
                            found_next = 1'b1;
                            fidx_next  = pidx_reg;
                        end
                        if (!valid_reg[pidx_reg] && !ffree_reg)
                        begin
                            ffree_next = 1'b1;
                            free_next  = pidx_reg;
                        end
                    end
                end
                if (scan_done)
                begin
                    if (pop_cmd)
                    begin
                        if (found_reg)
                        begin
                            cur_next   = best_reg;
                            slot_next  = fidx_reg;
                            state_next = S_PRD;
                        end
                        else
                        begin
                            res_next        = '0;
                            res_next.status = steq_pkg::ST_EMPTY;
                            ro_next         = 1'b0;
                            state_next      = S_RES;
                        end
                    end
                    else if (found_reg)
                    begin
                        slot_next  = fidx_reg;
                        state_next = S_LRD;
                    end
                    else if (ffree_reg)
                    begin
                        slot_next  = free_reg;
                        state_next = S_ALLOC;
                    end
                    else
                    begin
                        res_next        = '0;
                        res_next.status = steq_pkg::ST_REJ;
                        state_next      = S_RES;
                    end
                end
            end

            S_ALLOC:
            begin
                st_we = 1'b1;
                ls_we = 1'b1;
                valid_next[slot_reg] = 1'b1;
                state_next = S_LRD;
            end

            S_LRD:
            begin
                state_next = S_LUPD;
            end

            S_LUPD:
            begin
                if (use_r)
                begin
                    recyc_next = lk_rdata;
                end
                else
                begin
                    fresh_next = fresh_reg + 1'b1;
                end
                c = (item_reg.cmd == steq_pkg::CMD_PUSH) ? steq_pkg::CLS_ACTIVE : item_reg.cls;
                tg_we    = 1'b1;
                tg_waddr = e[EW-1:0];
                tg_wdata = {c, item_reg.tag[SB-1:0]};
                lk_we    = 1'b1;
                lk_waddr = e[EW-1:0];
                res_next        = '0;
                res_next.status = steq_pkg::ST_ACC;
                state_next      = S_RES;
                if (item_reg.cmd == steq_pkg::CMD_PUSH)
                begin
                    lk_wdata = r[0].head;
                    if (r[0].head == NULL_LINK)
                    begin
                        r[0].tail = e;
                    end
                    r[0].head = e;
                end
                else if (r[c].head == NULL_LINK)
                begin
                    r[c].head = e;
                    r[c].tail = e;
                end
                else
                begin
                    // The old tail still needs its link; the single link port takes it next.
                    tail_next  = r[c].tail;
                    ent_next   = e;
                    r[c].tail  = e;
                    state_next = S_LINK;
                end
                ls_we    = 1'b1;
                ls_wdata = r;
            end

            S_LINK:
            begin
                lk_we    = 1'b1;
                lk_waddr = tail_reg[EW-1:0];
                lk_wdata = ent_reg;
                state_next = S_RES;
            end

            S_PRD:
            begin
                state_next = S_PCHK;
            end

            S_PCHK:
            begin
                // Nonblocking, then read-write sync, move up when active has run dry.
                if (r[0].head == NULL_LINK)
                begin
                    r[0] = r[1];
                    r[1].head = NULL_LINK;
                    r[1].tail = NULL_LINK;
                end
                if (r[0].head == NULL_LINK)
                begin
                    r[0] = r[2];
                    r[2].head = NULL_LINK;
                    r[2].tail = NULL_LINK;
                end
                row_next = r;
                if (r[0].head != NULL_LINK)
                begin
                    c = steq_pkg::CLS_ACTIVE;
                end
                else if (r[3].head != NULL_LINK)
                begin
                    c = steq_pkg::CLS_ROSYNC;
                end
                else
                begin
                    c = steq_pkg::CLS_DEL;
                end
                if (r[0].head == NULL_LINK && r[3].head == NULL_LINK &&
                    r[4].head == NULL_LINK)
                begin
                    // Slot has nothing left: retire it and look for the next one.
                    valid_next[slot_reg] = 1'b0;
                    ro_next    = 1'b0;
                    scan_next  = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    ffree_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    if (c != steq_pkg::CLS_ACTIVE)
                    begin
                        ro_next = 1'b1;
                    end
                    ent_next   = r[c].head;
                    pcls_next  = c;
                    lk_raddr   = r[c].head[EW-1:0];
                    tg_raddr   = r[c].head[EW-1:0];
                    state_next = S_PPOP;
                end
            end

            S_PPOP:
            begin
                r = row_reg;
                r[pcls_reg].head = lk_rdata;
                if (lk_rdata == NULL_LINK)
                begin
                    r[pcls_reg].tail = NULL_LINK;
                end
                ls_we    = 1'b1;
                ls_wdata = r;
                lk_we    = 1'b1;
                lk_waddr = ent_reg[EW-1:0];
                lk_wdata = recyc_reg;
                recyc_next = ent_reg;
                res_next.status = steq_pkg::ST_RET;
                res_next.tag    = steq_pkg::TAG_W'(tg_rdata[SB-1:0]);
                res_next.cls    = tg_rdata[SB+2:SB];
                res_next.etime  = cur_reg;
                state_next      = S_RES;
            end

            S_RES:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cur_reg   <= '0;
            ro_reg    <= 1'b0;
            valid_reg <= '0;
            fresh_reg <= '0;
            recyc_reg <= NULL_LINK;
            scan_reg  <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
            ffree_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
            ro_reg    <= ro_next;
            valid_reg <= valid_next;
            fresh_reg <= fresh_next;
            recyc_reg <= recyc_next;
            scan_reg  <= scan_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
            ffree_reg <= ffree_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        pidx_reg   <= pidx_next;
        fidx_reg   <= fidx_next;
        free_reg   <= free_next;
        best_reg   <= best_next;
        target_reg <= target_next;
        slot_reg   <= slot_next;
        row_reg    <= row_next;
        ent_reg    <= ent_next;
        tail_reg   <= tail_next;
        pcls_reg   <= pcls_next;
    end

endmodule
